[rtl/mst_pkg.sv]
// Shared types and codes for the multiset table block.
// No dependencies; used by mst_seq and multiset_table.
`default_nettype none

package mst_pkg;

  // Width of the entry_count result field
  localparam int unsigned CountFieldW = 5;

  // Operation codes carried in the action field
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } mst_act_e;

  // One result item as handed from the sequencer to the output register
  typedef struct packed {
    logic                   success;
    logic                   full_reject;
    logic [CountFieldW-1:0] entry_count;
  } mst_res_t;

endpackage : mst_pkg

`default_nettype wire

[rtl/multiset_table.sv]
// Multiset table top level: sequencer, entry store and output register.
// Depends on mst_pkg, mst_mem and mst_seq.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries action_i and value_i:
//   insert appends, remove deletes the first match and compacts the rest,
//   query looks the value up. Every item yields one result on the output
//   channel (out_valid_o/out_ready_i): success_o, full_reject_o and the
//   entry count after the operation (low 5 bits).
//   Timing: an insert's result is registered in the sequencer and then in
//   the output register. Remove and query scan one entry per cycle through
//   the single comparator and the memory read port; a remove then moves one
//   later entry per cycle. The next item can transfer once the output
//   register has taken the result. One item is in work at a time;
//   in_ready_o is high only while the sequencer is idle.
//   The output register holds a finished result while the receiver stalls;
//   the sequencer can take and process the next item meanwhile and waits
//   with its result until the register frees.
//   Reset empties the table at once (count to zero); the store itself is
//   not cleared, since entries at or above the count are never read.
`default_nettype none

module multiset_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic signed [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             success_o,
  output logic             full_reject_o,
  output logic [4:0]       entry_count_o
);
  import mst_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            we;
  logic [IdxW-1:0] waddr;
  logic [31:0]     wdata;
  logic            re;
  logic [IdxW-1:0] raddr;
  logic [31:0]     rdata;
  logic            res_valid;
  logic            res_ready;
  mst_res_t        res;

  logic     out_valid_q, out_valid_d;
  mst_res_t out_q, out_d;

  mst_mem #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mst_seq #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = out_q.success;
  assign full_reject_o = out_q.full_reject;
  assign entry_count_o = out_q.entry_count;

`ifndef SYNTH
  // A refused insert never reports success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(success_o && full_reject_o))
    else $error("success and full_reject both set");

  // A refused insert reports a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_reject_o) |-> (entry_count_o == 5'(CAPACITY)))
    else $error("full_reject with count not at capacity");

  // The sequencer is busy in the cycle after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item taken while previous item still in work");
`endif

endmodule : multiset_table

`default_nettype wire

[rtl/mst_mem.sv]
// Entry store: one write port, one read port with registered read data.
// Standalone; instantiated by multiset_table.
`default_nettype none

module mst_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [31:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [31:0]      rdata_o
);

  logic [31:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : mst_mem

`default_nettype wire

[rtl/mst_seq.sv]
// Sequencer: linear search with a shared 32-bit comparator, then compaction.
// Depends on mst_pkg; drives the ports of mst_mem.
`default_nettype none

module mst_seq #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned IdxW     = 4,
  parameter int unsigned CntW     = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // item input
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [31:0]       value_i,
  // result toward the output register
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output mst_pkg::mst_res_t      res_o,
  // memory ports
  output logic                   we_o,
  output logic      [IdxW-1:0]   waddr_o,
  output logic      [31:0]       wdata_o,
  output logic                   re_o,
  output logic      [IdxW-1:0]   raddr_o,
  input  wire logic [31:0]       rdata_i
);
  import mst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  mst_act_e        act_q, act_d;
  logic [31:0]     val_q, val_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic            succ_q, succ_d;
  logic            full_q, full_d;

  logic [CntW-1:0]          idx_p1;
  logic [CntW-1:0]          idx_p2;
  logic                     hit;
  logic [CntW+CountFieldW-1:0] cnt_ext;

  assign idx_p1 = CntW'(idx_q) + CntW'(1);
  assign idx_p2 = CntW'(idx_q) + CntW'(2);

  // The one shared comparator: stored entry against the looked-up value
  assign hit = (rdata_i == val_q);

  assign cnt_ext = {{CountFieldW{1'b0}}, count_q};

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    val_d   = val_q;
    idx_d   = idx_q;
    count_d = count_q;
    succ_d  = succ_q;
    full_d  = full_q;
    we_o    = 1'b0;
    waddr_o = idx_q;
    wdata_o = rdata_i;
    re_o    = 1'b0;
    raddr_o = idx_p1[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d  = mst_act_e'(action_i);
          val_d  = value_i;
          idx_d  = '0;
          succ_d = 1'b0;
          full_d = 1'b0;
          state_d = S_DONE;
          case (mst_act_e'(action_i))
            ACT_INSERT: begin
              if (count_q >= CntW'(Capacity)) begin
                full_d = 1'b1;
              end else begin
                we_o    = 1'b1;
                waddr_o = count_q[IdxW-1:0];
                wdata_o = value_i;
                count_d = count_q + CntW'(1);
                succ_d  = 1'b1;
              end
            end
            ACT_REMOVE, ACT_QUERY: begin
              if (count_q != '0) begin
                re_o    = 1'b1;
                raddr_o = '0;
                state_d = S_CMP;
              end
            end
            default: ;
          endcase
        end
      end

      // One entry compared per cycle
      S_CMP: begin
        if (hit) begin
          succ_d = 1'b1;
          if (act_q == ACT_REMOVE) begin
            count_d = count_q - CntW'(1);
            if (idx_p1 < count_q) begin
              re_o    = 1'b1;
              state_d = S_SHIFT;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            state_d = S_DONE;
          end
        end else if (idx_p1 < count_q) begin
          re_o    = 1'b1;
          idx_d   = idx_p1[IdxW-1:0];
        end else begin
          state_d = S_DONE;
        end
      end

      // Move entry idx+1 down to idx, one per cycle; count_q is already reduced
      S_SHIFT: begin
        we_o  = 1'b1;
        idx_d = idx_p1[IdxW-1:0];
        if (idx_p1 < count_q) begin
          re_o    = 1'b1;
          raddr_o = idx_p2[IdxW-1:0];
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      act_q   <= ACT_INSERT;
      val_q   <= '0;
      idx_q   <= '0;
      succ_q  <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      act_q   <= act_d;
      val_q   <= val_d;
      idx_q   <= idx_d;
      succ_q  <= succ_d;
      full_q  <= full_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.success     = succ_q;
    res_o.full_reject = full_q;
    res_o.entry_count = cnt_ext[CountFieldW-1:0];
  end

endmodule : mst_seq

`default_nettype wire
